>>> rtl/fsa_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the fixed-step accumulator.
// Used by fsa_arith_unit and fixed_step_accumulator; depends on nothing else.
package fsa_pkg;

  // Field widths.
  localparam int unsigned TIME_W   = 64;
  localparam int unsigned STEP_W   = 32;
  localparam int unsigned SCALE_W  = 24;
  localparam int unsigned CLAMP_W  = 32;
  localparam int unsigned CATCH_W  = 16;
  localparam int unsigned FRAME_W  = 32;
  localparam int unsigned FRAC_W   = 16;
  localparam int unsigned MODE_W   = 2;
  localparam int unsigned REG_W    = 2;
  localparam int unsigned CONS_W   = STEP_W + CATCH_W;
  localparam int unsigned OUT_W    = 224;

  // Arithmetic unit sizes.
  localparam int unsigned PROD_W    = TIME_W + SCALE_W;
  localparam int unsigned MUL_STEPS = SCALE_W;
  localparam int unsigned DIV_STEPS = TIME_W;
  localparam int unsigned CNT_W     = 6;

  // Register reset values.
  localparam logic [STEP_W-1:0]  STEP_RESET  = 32'd16666667;
  localparam logic [SCALE_W-1:0] SCALE_RESET = 24'd65536;
  localparam logic [CLAMP_W-1:0] CLAMP_RESET = 32'd0;
  localparam logic [CATCH_W-1:0] CATCH_RESET = 16'd8;

  // Event kinds.
  localparam logic [MODE_W-1:0] MODE_BEGIN = 2'd0;
  localparam logic [MODE_W-1:0] MODE_RESET = 2'd1;
  localparam logic [MODE_W-1:0] MODE_END   = 2'd2;

  // Register indexes.
  localparam logic [REG_W-1:0] REG_STEP  = 2'd0;
  localparam logic [REG_W-1:0] REG_SCALE = 2'd1;
  localparam logic [REG_W-1:0] REG_CLAMP = 2'd2;
  localparam logic [REG_W-1:0] REG_CATCH = 2'd3;

  localparam logic [FRAC_W-1:0] FRAC_MAX = '1;

  typedef enum logic {
    FSA_OP_MUL,
    FSA_OP_DIV
  } fsa_op_t;

  // Command from the sequencer to the arithmetic unit.
  typedef struct packed {
    logic    start;
    fsa_op_t op;
  } fsa_cmd_t;

  // Status back from the arithmetic unit.
  typedef struct packed {
    logic busy;
    logic done;
  } fsa_stat_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SCALE,
    ST_SCALE_W,
    ST_ACC,
    ST_AVAIL,
    ST_AVAIL_W,
    ST_CLAMP,
    ST_CLAMP_W,
    ST_RUN,
    ST_CONS,
    ST_CONS_W,
    ST_UPDATE,
    ST_FRAC,
    ST_FRAC_W,
    ST_DONE
  } fsa_state_t;

endpackage

>>> rtl/fixed_step_accumulator.sv
`timescale 1ns / 1ps
// Fixed-step accumulator top level: event sequencer, state and stream ports.
// Depends on fsa_pkg and fsa_arith_unit.
//
// Reset and end-frame events are taken straight from idle and give no result. A
// begin-frame event keeps the input not ready from its transfer until its result
// is loaded, while the sequencer runs the 24-step shift-add multiply that scales
// the elapsed time, the 64-step restoring divide that counts the available steps
// and the multiply that forms the consumed time. A divide for the stall budget is
// added when a budget is set, and a divide for the blend fraction when the
// leftover is below one step. With a zero step only the scaling runs. All
// arithmetic shares one bit-serial unit. A finished result sits in the output
// register until taken, and the next event may be accepted meanwhile; a later
// result waits in the sequencer, with the input not ready, while that register is
// still full.
module fixed_step_accumulator (
  input  logic                              clk,
  input  logic                              rst,
  // Input events.
  input  logic                              s_tvalid,
  output logic                              s_tready,
  input  logic [fsa_pkg::TIME_W-1:0]        s_tdata,   // now_time
  input  logic [fsa_pkg::MODE_W-1:0]        s_tuser,   // mode
  // Frame results.
  output logic                              m_tvalid,
  input  logic                              m_tready,
  // elapsed_wall_ns[63:0], step_size_ns[95:64], frame_number[127:96],
  // steps_to_run[143:128], simulated_time_ns[207:144], blend_fraction_q16[223:208]
  output logic [fsa_pkg::OUT_W-1:0]         m_tdata,
  // Register writes.
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [fsa_pkg::REG_W-1:0]         cfg_index,
  input  logic [fsa_pkg::STEP_W-1:0]        cfg_data
);
  import fsa_pkg::*;

  fsa_state_t          state, state_next;
  fsa_cmd_t            ucmd;
  fsa_stat_t           ustat;
  logic [TIME_W-1:0]   uopa;
  logic [STEP_W-1:0]   uopb;
  logic [PROD_W-1:0]   uprod;
  logic [TIME_W-1:0]   uquo;

  // Configuration registers.
  logic [STEP_W-1:0]   step_len;
  logic [SCALE_W-1:0]  time_scale;
  logic [CLAMP_W-1:0]  stall_clamp;
  logic [CATCH_W-1:0]  max_catchup;

  // Architectural state.
  logic [TIME_W-1:0]   prev_time;
  logic [TIME_W-1:0]   time_acc;
  logic [TIME_W-1:0]   sim_total;
  logic [FRAME_W-1:0]  frame_count;

  // Per-event working registers.
  logic [TIME_W-1:0]   wall;
  logic [TIME_W-1:0]   scaled;
  logic [TIME_W-1:0]   avail;
  logic [CATCH_W-1:0]  budget;
  logic [CATCH_W-1:0]  run;
  logic [CONS_W-1:0]   consume;
  logic [FRAC_W-1:0]   frac;

  logic                in_xfer;
  logic                out_load;
  logic [TIME_W:0]     acc_sum;
  logic                step_zero;

  assign s_tready  = (state == ST_IDLE);
  assign cfg_ready = 1'b1;
  assign in_xfer   = s_tvalid && s_tready;
  assign out_load  = (state == ST_DONE) && (!m_tvalid || m_tready);
  assign acc_sum   = {1'b0, time_acc} + {1'b0, scaled};
  assign step_zero = (step_len == '0);

  fsa_arith_unit u_arith (
    .clk      (clk),
    .rst      (rst),
    .cmd      (ucmd),
    .opa      (uopa),
    .opb      (uopb),
    .stat     (ustat),
    .product  (uprod),
    .quotient (uquo)
  );

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and arithmetic unit commands.
  always_comb begin
    state_next = state;
    ucmd.start = 1'b0;
    ucmd.op    = FSA_OP_MUL;
    uopa       = '0;
    uopb       = step_len;
    case (state)
      ST_IDLE: begin
        if (in_xfer && s_tuser == MODE_BEGIN) begin
          state_next = ST_SCALE;
        end
      end
      ST_SCALE: begin
        ucmd.start = 1'b1;
        uopa       = wall;
        uopb       = {{(STEP_W-SCALE_W){1'b0}}, time_scale};
        state_next = ST_SCALE_W;
      end
      ST_SCALE_W: begin
        if (ustat.done) begin
          state_next = ST_ACC;
        end
      end
      ST_ACC: begin
        state_next = step_zero ? ST_UPDATE : ST_AVAIL;
      end
      ST_AVAIL: begin
        ucmd.start = 1'b1;
        ucmd.op    = FSA_OP_DIV;
        uopa       = time_acc;
        state_next = ST_AVAIL_W;
      end
      ST_AVAIL_W: begin
        if (ustat.done) begin
          state_next = (stall_clamp != '0) ? ST_CLAMP : ST_RUN;
        end
      end
      ST_CLAMP: begin
        ucmd.start = 1'b1;
        ucmd.op    = FSA_OP_DIV;
        uopa       = {{(TIME_W-CLAMP_W){1'b0}}, stall_clamp};
        state_next = ST_CLAMP_W;
      end
      ST_CLAMP_W: begin
        if (ustat.done) begin
          state_next = ST_RUN;
        end
      end
      ST_RUN: begin
        state_next = ST_CONS;
      end
      ST_CONS: begin
        ucmd.start = 1'b1;
        uopa       = {{(TIME_W-STEP_W){1'b0}}, step_len};
        uopb       = {{(STEP_W-CATCH_W){1'b0}}, run};
        state_next = ST_CONS_W;
      end
      ST_CONS_W: begin
        if (ustat.done) begin
          state_next = ST_UPDATE;
        end
      end
      ST_UPDATE: begin
        state_next = ST_FRAC;
      end
      ST_FRAC: begin
        if (step_zero || time_acc >= {{(TIME_W-STEP_W){1'b0}}, step_len}) begin
          state_next = ST_DONE;
        end else begin
          // Leftover is below one step, so it fits in 32 bits before the shift.
          ucmd.start = 1'b1;
          ucmd.op    = FSA_OP_DIV;
          uopa       = {time_acc[TIME_W-FRAC_W-1:0], {FRAC_W{1'b0}}};
          state_next = ST_FRAC_W;
        end
      end
      ST_FRAC_W: begin
        if (ustat.done) begin
          state_next = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_load) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      step_len    <= STEP_RESET;
      time_scale  <= SCALE_RESET;
      stall_clamp <= CLAMP_RESET;
      max_catchup <= CATCH_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_STEP:  step_len    <= cfg_data;
        REG_SCALE: time_scale  <= cfg_data[SCALE_W-1:0];
        REG_CLAMP: stall_clamp <= cfg_data;
        REG_CATCH: max_catchup <= cfg_data[CATCH_W-1:0];
        default:   step_len    <= step_len;
      endcase
    end
  end

  // Timestamp, accumulator, simulated time and frame count.
  always_ff @(posedge clk) begin
    if (rst) begin
      prev_time   <= '0;
      time_acc    <= '0;
      sim_total   <= '0;
      frame_count <= '0;
    end else begin
      if (in_xfer) begin
        case (s_tuser)
          MODE_BEGIN: prev_time <= s_tdata;
          MODE_RESET: begin
            prev_time   <= s_tdata;
            time_acc    <= '0;
            sim_total   <= '0;
            frame_count <= '0;
          end
          MODE_END:   frame_count <= frame_count + 1'b1;
          default:    prev_time <= prev_time;
        endcase
      end
      // Saturating add of the scaled elapsed time.
      if (state == ST_ACC) begin
        time_acc <= acc_sum[TIME_W] ? '1 : acc_sum[TIME_W-1:0];
      end
      if (state == ST_UPDATE) begin
        time_acc  <= time_acc - {{(TIME_W-CONS_W){1'b0}}, consume};
        sim_total <= sim_total + {{(TIME_W-CONS_W){1'b0}}, consume};
      end
    end
  end

  // Per-event working values.
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      wall <= (s_tdata >= prev_time) ? (s_tdata - prev_time) : '0;
    end
    case (state)
      ST_SCALE_W: begin
        if (ustat.done) begin
          // Drop 16 fraction bits and saturate anything above 64 bits.
          scaled <= (uprod[PROD_W-1:TIME_W+FRAC_W] != '0)
                  ? '1 : uprod[TIME_W+FRAC_W-1:FRAC_W];
        end
      end
      ST_ACC: begin
        run     <= '0;
        consume <= '0;
        budget  <= max_catchup;
      end
      ST_AVAIL_W: begin
        if (ustat.done) begin
          avail <= uquo;
        end
      end
      ST_CLAMP_W: begin
        if (ustat.done && uquo < {{(TIME_W-CATCH_W){1'b0}}, max_catchup}) begin
          budget <= uquo[CATCH_W-1:0];
        end
      end
      ST_RUN: begin
        run <= (avail < {{(TIME_W-CATCH_W){1'b0}}, budget}) ? avail[CATCH_W-1:0] : budget;
      end
      ST_CONS_W: begin
        if (ustat.done) begin
          consume <= uprod[CONS_W-1:0];
        end
      end
      ST_FRAC: begin
        frac <= step_zero ? '0 : FRAC_MAX;
      end
      ST_FRAC_W: begin
        if (ustat.done) begin
          frac <= uquo[FRAC_W-1:0];
        end
      end
      default: begin
        frac <= frac;
      end
    endcase
  end

  // Output register: holds a finished result until its transfer.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      m_tdata <= {frac, sim_total, run, frame_count, step_len, wall};
    end
  end

  // The shared unit is idle whenever a new event can be taken.
  a_idle_unit: assert property (@(posedge clk) disable iff (rst)
    s_tready |-> !ustat.busy)
    else $error("input ready while the arithmetic unit is busy");

  // Unit results arrive only where the sequencer waits for them.
  a_done_in_wait: assert property (@(posedge clk) disable iff (rst)
    ustat.done |-> (state == ST_SCALE_W || state == ST_AVAIL_W || state == ST_CLAMP_W ||
                    state == ST_CONS_W || state == ST_FRAC_W))
    else $error("arithmetic result outside a wait state");

  // A zero step grants nothing and reports no fraction.
  a_zero_step: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tdata[95:64] == '0) |-> (m_tdata[143:128] == '0 && m_tdata[223:208] == '0))
    else $error("zero step gave steps or a fraction");

  // The grant never exceeds the catch-up limit.
  a_catchup: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[143:128] <= max_catchup))
    else $error("steps granted beyond the catch-up limit");

endmodule

>>> rtl/fsa_arith_unit.sv
`timescale 1ns / 1ps
// Shared bit-serial arithmetic unit: shift-add multiply and restoring divide.
// Depends on fsa_pkg.
module fsa_arith_unit (
  input  logic                              clk,
  input  logic                              rst,
  input  fsa_pkg::fsa_cmd_t                 cmd,
  input  logic [fsa_pkg::TIME_W-1:0]        opa,
  input  logic [fsa_pkg::STEP_W-1:0]        opb,
  output fsa_pkg::fsa_stat_t                stat,
  output logic [fsa_pkg::PROD_W-1:0]        product,
  output logic [fsa_pkg::TIME_W-1:0]        quotient
);
  import fsa_pkg::*;

  logic                busy;
  logic                done;
  fsa_op_t             op;
  logic [CNT_W-1:0]    cnt;
  logic [TIME_W-1:0]   mcand;
  logic [SCALE_W-1:0]  mplier;
  logic [STEP_W-1:0]   rem;
  logic [STEP_W-1:0]   dvsr;
  logic [STEP_W:0]     trial;
  logic                fits;
  logic [PROD_W-1:0]   prod_next;

  // One multiply step: shift the product and add the multiplicand on a set bit.
  assign prod_next = {product[PROD_W-2:0], 1'b0}
                   + (mplier[SCALE_W-1] ? {{(PROD_W-TIME_W){1'b0}}, mcand} : '0);

  // One divide step: bring down the next dividend bit and try the divisor.
  // The remainder stays below the divisor, so it always fits in STEP_W bits.
  assign trial = {rem, quotient[TIME_W-1]};
  assign fits  = (trial >= {1'b0, dvsr});

  // Control: busy flag, iteration count and completion pulse.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
      op   <= FSA_OP_MUL;
    end else begin
      done <= 1'b0;
      if (cmd.start) begin
        busy <= 1'b1;
        op   <= cmd.op;
        cnt  <= (cmd.op == FSA_OP_MUL) ? CNT_W'(MUL_STEPS - 1) : CNT_W'(DIV_STEPS - 1);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    if (cmd.start) begin
      product  <= '0;
      mcand    <= opa;
      mplier   <= opb[SCALE_W-1:0];
      rem      <= '0;
      quotient <= opa;
      dvsr     <= opb;
    end else if (busy) begin
      if (op == FSA_OP_MUL) begin
        product <= prod_next;
        mplier  <= {mplier[SCALE_W-2:0], 1'b0};
      end else begin
        rem      <= fits ? STEP_W'(trial - {1'b0, dvsr}) : trial[STEP_W-1:0];
        quotient <= {quotient[TIME_W-2:0], fits};
      end
    end
  end

  assign stat.busy = busy;
  assign stat.done = done;

  // The sequencer never starts a new operation on top of a running one.
  a_no_start_busy: assert property (@(posedge clk) disable iff (rst)
    cmd.start |-> !busy)
    else $error("arith unit started while busy");

  // Completion follows a busy cycle and leaves the unit idle.
  a_done_after_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> ($past(busy) && !busy))
    else $error("arith unit done without a running operation");

  // A divide never sees a zero divisor.
  a_div_nonzero: assert property (@(posedge clk) disable iff (rst)
    (cmd.start && cmd.op == FSA_OP_DIV) |-> (opb != '0))
    else $error("arith unit divide by zero");

endmodule

>>> sim/fixed_step_accumulator_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for fixed_step_accumulator: timed event streams in, frame results out.
// Depends on fsa_pkg and the fixed_step_accumulator RTL; keeps its own model of the frame timing.
module fixed_step_accumulator_tb;
  import fsa_pkg::*;

  localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;
  localparam int unsigned MAX_GAP = 12;
  localparam int unsigned DRAIN_CYCLES = 300;
  localparam int unsigned REPORT_LIMIT = 10;
  localparam int unsigned RANDOM_EVENTS = 80;

  // One timed event waiting to go out.
  typedef struct {
    logic [MODE_W-1:0] mode;
    logic [TIME_W-1:0] now;
    bit                drain;
  } timed_event_t;

  // One frame result, field by field.
  typedef struct {
    logic [TIME_W-1:0]  elapsed;
    logic [STEP_W-1:0]  step_size;
    logic [FRAME_W-1:0] frame_no;
    logic [CATCH_W-1:0] steps;
    logic [TIME_W-1:0]  sim_time;
    logic [FRAC_W-1:0]  blend;
  } frame_t;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                s_tvalid = 1'b0;
  logic                s_tready;
  logic [TIME_W-1:0]   s_tdata = '0;   // now_time
  logic [MODE_W-1:0]   s_tuser = MODE_BEGIN;   // mode
  logic                m_tvalid;
  logic                m_tready = 1'b0;
  // elapsed_wall_ns, step_size_ns, frame_number, steps_to_run, simulated_time_ns,
  // blend_fraction_q16
  logic [OUT_W-1:0]    m_tdata;
  logic                cfg_valid = 1'b0;
  logic                cfg_ready;
  logic [REG_W-1:0]    cfg_index = REG_STEP;
  logic [STEP_W-1:0]   cfg_data = '0;

  // Register copies, at their reset values.
  logic [STEP_W-1:0]   step_ns = STEP_RESET;
  logic [SCALE_W-1:0]  scale_q16 = SCALE_RESET;
  logic [CLAMP_W-1:0]  clamp_ns = CLAMP_RESET;
  logic [CATCH_W-1:0]  catchup_max = CATCH_RESET;

  // Timing state of the model.
  logic [TIME_W-1:0]   last_stamp = '0;
  logic [TIME_W-1:0]   time_bank = '0;
  logic [TIME_W-1:0]   sim_total = '0;
  logic [FRAME_W-1:0]  frame_tally = '0;

  timed_event_t queued_events[$];
  frame_t       expected_frames[$];

  bit          no_idle = 1'b0;
  int unsigned gap_left = 0;
  int unsigned stall_left = 0;
  int unsigned mismatches = 0;
  int unsigned events_taken = 0;
  int unsigned frames_checked = 0;
  int unsigned settings_used = 1;

  fixed_step_accumulator dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  // Advances the timing state by one event; returns 1 when a frame result is due.
  function automatic bit compute_frame(input logic [MODE_W-1:0] mode,
                                       input logic [TIME_W-1:0] now, output frame_t res);
    logic [TIME_W-1:0]         wall;
    logic [TIME_W-1:0]         scaled;
    logic [TIME_W+SCALE_W-1:0] product;
    logic [TIME_W:0]           sum;
    logic [TIME_W-1:0]         step64;
    logic [TIME_W-1:0]         avail;
    logic [TIME_W-1:0]         budget;
    logic [TIME_W-1:0]         run;
    logic [TIME_W-1:0]         consume;
    logic [TIME_W-1:0]         quot;
    logic [FRAC_W-1:0]         frac;
    res = '{default: '0};
    if (mode == MODE_RESET) begin
      last_stamp = now;
      time_bank = '0;
      sim_total = '0;
      frame_tally = '0;
      return 1'b0;
    end
    if (mode == MODE_END) begin
      frame_tally = frame_tally + 1'b1;
      return 1'b0;
    end
    if (mode != MODE_BEGIN) return 1'b0;

    // Elapsed time clips to zero when the clock runs backwards.
    wall = (now >= last_stamp) ? now - last_stamp : '0;
    last_stamp = now;

    // Q8.16 scaling and the accumulator add both saturate.
    product = {{SCALE_W{1'b0}}, wall} * {{TIME_W{1'b0}}, scale_q16};
    scaled = (product[TIME_W+SCALE_W-1:TIME_W+16] != 0) ? '1 : product[TIME_W+15:16];
    sum = {1'b0, time_bank} + {1'b0, scaled};
    time_bank = sum[TIME_W] ? '1 : sum[TIME_W-1:0];

    // Grant: available steps, limited by catch-up count and stall budget.
    step64 = {{(TIME_W-STEP_W){1'b0}}, step_ns};
    avail = (step64 != 0) ? time_bank / step64 : '0;
    budget = {{(TIME_W-CATCH_W){1'b0}}, catchup_max};
    if (clamp_ns != 0 && step64 != 0) begin
      if ({{(TIME_W-CLAMP_W){1'b0}}, clamp_ns} / step64 < budget)
        budget = {{(TIME_W-CLAMP_W){1'b0}}, clamp_ns} / step64;
    end
    run = (avail < budget) ? avail : budget;
    consume = run * step64;
    time_bank = time_bank - consume;
    sim_total = sim_total + consume;

    // Leftover as a truncated Q0.16 fraction of one step.
    if (step64 == 0) begin
      frac = '0;
    end else if (time_bank >= step64) begin
      frac = FRAC_MAX;
    end else begin
      quot = (time_bank << 16) / step64;
      frac = (quot > {{(TIME_W-FRAC_W){1'b0}}, FRAC_MAX}) ? FRAC_MAX : quot[FRAC_W-1:0];
    end

    res.elapsed = wall;
    res.step_size = step_ns;
    res.frame_no = frame_tally;
    res.steps = run[CATCH_W-1:0];
    res.sim_time = sim_total;
    res.blend = frac;
    return 1'b1;
  endfunction

  // Event driver: presents queued events, with a random gap after each transfer.
  always @(posedge clk) begin : drive_events
    frame_t      fr;
    int unsigned gap;
    if (rst) begin
      s_tvalid <= 1'b0;
      gap_left <= 0;
    end else if (s_tvalid && s_tready) begin
      events_taken++;
      if (compute_frame(s_tuser, s_tdata, fr)) expected_frames.push_back(fr);
      void'(queued_events.pop_front());
      gap = no_idle ? 0 : $urandom_range(0, MAX_GAP);
      if (gap == 0 && queued_events.size() != 0 &&
          !(queued_events[0].drain && expected_frames.size() != 0)) begin
        s_tdata <= queued_events[0].now;
        s_tuser <= queued_events[0].mode;
      end else begin
        s_tvalid <= 1'b0;
        gap_left <= gap;
      end
    end else if (!s_tvalid) begin
      if (gap_left > 1) begin
        gap_left <= gap_left - 1;
      end else if (queued_events.size() != 0 &&
                   !(queued_events[0].drain && expected_frames.size() != 0)) begin
        s_tdata <= queued_events[0].now;
        s_tuser <= queued_events[0].mode;
        s_tvalid <= 1'b1;
        gap_left <= 0;
      end
    end
  end

  // Result monitor: random back-pressure, and a field-by-field compare of each transfer.
  always @(posedge clk) begin : check_frames
    frame_t      got;
    frame_t      want;
    int unsigned stall;
    if (rst) begin
      m_tready <= 1'b0;
      stall_left <= 0;
    end else if (m_tvalid && m_tready) begin
      got.elapsed = m_tdata[63:0];
      got.step_size = m_tdata[95:64];
      got.frame_no = m_tdata[127:96];
      got.steps = m_tdata[143:128];
      got.sim_time = m_tdata[207:144];
      got.blend = m_tdata[223:208];
      if (expected_frames.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_LIMIT)
          $display("%0t: unexpected frame result wall=%0d steps=%0d sim=%0d blend=%0d",
                   $realtime, got.elapsed, got.steps, got.sim_time, got.blend);
      end else begin
        want = expected_frames.pop_front();
        frames_checked++;
        if (got.elapsed != want.elapsed || got.step_size != want.step_size ||
            got.frame_no != want.frame_no || got.steps != want.steps ||
            got.sim_time != want.sim_time || got.blend != want.blend) begin
          mismatches++;
          if (mismatches <= REPORT_LIMIT) begin
            $display("%0t: frame mismatch, expected wall=%0d step=%0d frame=%0d steps=%0d",
                     $realtime, want.elapsed, want.step_size, want.frame_no, want.steps);
            $display("  sim=%0d blend=%0d; got wall=%0d step=%0d frame=%0d steps=%0d",
                     want.sim_time, want.blend, got.elapsed, got.step_size, got.frame_no,
                     got.steps);
            $display("  sim=%0d blend=%0d", got.sim_time, got.blend);
          end
        end
      end
      stall = no_idle ? 0 : $urandom_range(0, MAX_GAP);
      if (stall != 0) begin
        m_tready <= 1'b0;
        stall_left <= stall;
      end
    end else if (!m_tready) begin
      if (stall_left > 1) stall_left <= stall_left - 1;
      else m_tready <= 1'b1;
    end
  end

  task automatic push_event(input logic [MODE_W-1:0] mode, input logic [TIME_W-1:0] now,
                            input bit drain = 1'b0);
    timed_event_t ev;
    ev.mode = mode;
    ev.now = now;
    ev.drain = drain;
    queued_events.push_back(ev);
  endtask

  // Waits until every event has gone out and every result has come back.
  task automatic wait_drained();
    while (queued_events.size() != 0 || s_tvalid || expected_frames.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Writes all four registers back to back; called only while the block is idle.
  task automatic program_regs(input logic [STEP_W-1:0] step, input logic [SCALE_W-1:0] scale,
                              input logic [CLAMP_W-1:0] clamp,
                              input logic [CATCH_W-1:0] catchup);
    logic [STEP_W-1:0] vals[4];
    logic [REG_W-1:0]  regs[4];
    vals = '{step, STEP_W'(scale), clamp, STEP_W'(catchup)};
    regs = '{REG_STEP, REG_SCALE, REG_CLAMP, REG_CATCH};
    for (int i = 0; i < 4; i++) begin
      cfg_valid <= 1'b1;
      cfg_index <= regs[i];
      cfg_data <= vals[i];
      do @(posedge clk); while (!cfg_ready);
      case (regs[i])
        REG_STEP:  step_ns = vals[i];
        REG_SCALE: scale_q16 = vals[i][SCALE_W-1:0];
        REG_CLAMP: clamp_ns = vals[i];
        REG_CATCH: catchup_max = vals[i][CATCH_W-1:0];
        default: ;
      endcase
    end
    cfg_valid <= 1'b0;
    settings_used++;
  endtask

  // Mostly well-formed frame sequences after a reset event, with some noise mixed in.
  task automatic add_random_events(input int unsigned count);
    logic [TIME_W-1:0] t;
    logic [TIME_W-1:0] s64;
    logic [TIME_W-1:0] delta;
    int unsigned       made;
    int unsigned       pick;
    s64 = (step_ns == 0) ? 64'd1000000 : {32'd0, step_ns};
    case ($urandom_range(0, 2))
      0: t = {32'd0, $urandom};
      1: t = {$urandom, $urandom};
      default: t = '1 - $urandom_range(0, 1 << 30);
    endcase
    push_event(MODE_RESET, t);
    made = 1;
    while (made < count) begin
      pick = $urandom_range(0, 19);
      if (pick < 15) begin
        case ($urandom_range(0, 9))
          0: delta = '0;
          1, 2, 3, 4: delta = s64 * $urandom_range(0, 300) / 100;
          5: delta = s64 * $urandom_range(1, 20);
          6: delta = {32'd0, $urandom};
          7: delta = {$urandom, $urandom};
          8: delta = -{32'd0, $urandom};
          default: delta = $urandom_range(0, 255);
        endcase
        t = t + delta;
        push_event(MODE_BEGIN, t, $urandom_range(0, 39) == 0);
        made++;
        if ($urandom_range(0, 2) == 0) begin
          push_event(MODE_END, '0);
          made++;
        end
      end else if (pick < 17) begin
        push_event(MODE_END, {$urandom, $urandom});
        made++;
      end else if (pick == 17) begin
        t = {$urandom, $urandom};
        push_event(MODE_RESET, t);
        made++;
      end else if (pick == 18) begin
        // The block drops the unused kind; it does not count toward the total.
        push_event(MODE_UNUSED, {$urandom, $urandom});
      end else begin
        t = {$urandom, $urandom};
        push_event(MODE_BEGIN, t);
        made++;
      end
    end
  endtask

  // Stimulus: directed events on reset settings, then one phase per register setting.
  initial begin : stimulus
    logic [STEP_W-1:0] r_step;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // Zero elapsed, one exact step, half a step, catch-up limit, clock going back.
    push_event(MODE_BEGIN, 64'd0);
    push_event(MODE_RESET, 64'd1000);
    push_event(MODE_BEGIN, 64'd1000 + 64'd16666667);
    push_event(MODE_END, '0);
    push_event(MODE_BEGIN, 64'd1000 + 64'd16666667 + 64'd8333333);
    push_event(MODE_BEGIN, 64'd1000 + 64'd16666667 * 21);
    push_event(MODE_BEGIN, 64'd5);
    push_event(MODE_END, '1);
    push_event(MODE_UNUSED, '1);
    // Full-range timestamps: saturated fraction, then zero elapsed.
    push_event(MODE_BEGIN, '1);
    push_event(MODE_BEGIN, '1, 1'b1);
    push_event(MODE_END, '0);
    push_event(MODE_END, '0);
    push_event(MODE_RESET, '1);
    push_event(MODE_BEGIN, 64'd0);
    push_event(MODE_RESET, 64'd0);
    // Leftover just below one step, then landing exactly on it.
    push_event(MODE_BEGIN, 64'd16666666);
    push_event(MODE_BEGIN, 64'd16666667);
    wait_drained();

    for (int phase = 1; phase <= 10; phase++) begin
      case (phase)
        1: program_regs(32'd1000, 24'd65536, 32'd0, 16'd8);
        2: program_regs(32'd0, 24'd98304, 32'd5000, 16'd4);
        3: program_regs('1, '1, '1, '1);
        4: program_regs(32'd1, 24'd0, 32'd0, '1);
        5: program_regs(32'd1, 24'd65536, 32'd0, '1);
        6: program_regs(32'd16666667, 24'd32768, 32'd50000000, 16'd8);
        7: program_regs(32'd7, '1, 32'd3, 16'd0);
        default: begin
          case ($urandom_range(0, 3))
            0: r_step = $urandom_range(1, 1000);
            1: r_step = $urandom_range(1000, 50_000_000);
            2: r_step = $urandom;
            default: r_step = '0;
          endcase
          program_regs(r_step, SCALE_W'($urandom_range(0, 24'hFFFFFF)),
                       ($urandom_range(0, 1) == 0) ? '0 : CLAMP_W'($urandom),
                       ($urandom_range(0, 1) == 0) ? CATCH_W'($urandom_range(0, 16))
                                                   : CATCH_W'($urandom_range(0, 65535)));
        end
      endcase
      no_idle = (phase % 4 == 1);
      if (phase == 3) begin
        // Largest scale on the largest elapsed time saturates product and accumulator.
        push_event(MODE_RESET, 64'd0);
        push_event(MODE_BEGIN, '1);
        push_event(MODE_BEGIN, '1);
        push_event(MODE_RESET, 64'd0);
        push_event(MODE_BEGIN, 64'h8000_0000_0000_0000);
      end
      add_random_events(RANDOM_EVENTS);
      wait_drained();
    end

    if (expected_frames.size() != 0) begin
      mismatches += expected_frames.size();
      $display("%0d frame results never arrived", expected_frames.size());
    end
    $display("Covered %0d events and %0d frame results over %0d register settings,",
             events_taken, frames_checked, settings_used);
    $display("with random gaps and back-pressure; %0d mismatches.", mismatches);
    if (mismatches == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  // Watchdog for a hung handshake.
  initial begin : watchdog
    #15_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
